// ===== hdl/ertp_pkg.sv =====
// ----------------------------------------------------------------------------
// ertp_pkg
// Types, constants and helpers shared by the point transform block.
// ----------------------------------------------------------------------------
package ertp_pkg;

  localparam int CoordW     = 32;
  localparam int CoeffFrac  = 16;
  localparam int CoeffW     = CoeffFrac + 2;
  localparam int AngleW     = 26;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int CordicSteps = 20;
  localparam int StepW      = 5;
  localparam int TrigW      = 33;

  localparam logic signed [AngleW:0] Deg90  = 27'sd5898240;
  localparam logic signed [AngleW:0] Deg180 = 27'sd11796480;
  localparam logic signed [AngleW:0] Deg360 = 27'sd23592960;
  localparam logic signed [TrigW-1:0] CordicGain = 33'sd652032874;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ANGLE_X  = 3'd0,
    REG_ANGLE_Y  = 3'd1,
    REG_ANGLE_Z  = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] local_z;
    logic signed [CoordW-1:0] local_y;
    logic signed [CoordW-1:0] local_x;
  } point_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] global_z;
    logic signed [CoordW-1:0] global_y;
    logic signed [CoordW-1:0] global_x;
  } point_out_t;

  typedef logic signed [CoeffW-1:0] coeff_t;
  typedef coeff_t [8:0] matrix_t;

  // Arctangent of 2^-i in Q.16 degrees
  function automatic logic signed [AngleW:0] atan_deg(input logic [StepW-1:0] i);
    logic signed [AngleW:0] r;
    case (i)
      5'd0:  r = 27'sd2949120;
      5'd1:  r = 27'sd1740967;
      5'd2:  r = 27'sd919879;
      5'd3:  r = 27'sd466945;
      5'd4:  r = 27'sd234379;
      5'd5:  r = 27'sd117304;
      5'd6:  r = 27'sd58665;
      5'd7:  r = 27'sd29335;
      5'd8:  r = 27'sd14668;
      5'd9:  r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      5'd19: r = 27'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/ertp_matrix.sv =====
// ----------------------------------------------------------------------------
// ertp_matrix
// Builds the nine rotation coefficients from three angles with one shared
// CORDIC (one step a cycle) and one shared multiplier (one product a cycle).
// ----------------------------------------------------------------------------
module ertp_matrix import ertp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rebuild,
  input  logic signed [AngleW-1:0] angle_x,
  input  logic signed [AngleW-1:0] angle_y,
  input  logic signed [AngleW-1:0] angle_z,
  output matrix_t                  coeffs
);

  typedef enum logic [2:0] {
    S_IDLE, S_REDUCE, S_ROT, S_STORE, S_MUL, S_DONE
  } state_e;

  state_e state;
  logic [1:0] axis;
  logic [StepW-1:0] step;
  logic signed [AngleW:0] ang;
  logic flip;
  logic signed [TrigW-1:0] cx, cy;
  logic signed [TrigW-1:0] trig [6];  // sx cx sy cy sz cz
  logic [4:0] op;
  logic signed [TrigW-1:0] czsy, szsy;
  logic signed [TrigW-1:0] mul_a, mul_b;
  logic signed [66:0] prod;
  logic signed [67:0] acc;
  logic signed [AngleW-1:0] ang_in;
  logic signed [AngleW:0] ang_mod, ang_wrap;

  // Select the angle under work and wrap it into (-180, 180]
  always_comb begin
    unique case (axis)
      2'd0:    ang_in = angle_x;
      2'd1:    ang_in = angle_y;
      default: ang_in = angle_z;
    endcase
    ang_mod = {ang_in[AngleW-1], ang_in};
    // Range is [-512, 512) so one correction in each direction suffices
    if (ang_mod >= Deg360) ang_mod = ang_mod - Deg360;
    else if (ang_mod <= -Deg360) ang_mod = ang_mod + Deg360;
    if (ang_mod < 0) ang_mod = ang_mod + Deg360;
    if (ang_mod > Deg180) ang_mod = ang_mod - Deg360;
    ang_wrap = ang_mod;
  end

  // Floor shifts for one CORDIC step
  logic signed [TrigW-1:0] dx, dy;
  assign dx = cy >>> step;
  assign dy = cx >>> step;

  // Operand pairs for the product schedule
  logic signed [TrigW-1:0] sx, ccx, sy, ccy, sz, ccz;
  assign sx = trig[0]; assign ccx = trig[1];
  assign sy = trig[2]; assign ccy = trig[3];
  assign sz = trig[4]; assign ccz = trig[5];

  // Pick both operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      5'd0:  begin mul_a = ccz;  mul_b = sy;  end
      5'd1:  begin mul_a = sz;   mul_b = sy;  end
      5'd2:  begin mul_a = ccz;  mul_b = ccy; end
      5'd3:  begin mul_a = czsy; mul_b = sx;  end
      5'd4:  begin mul_a = sz;   mul_b = ccx; end
      5'd5:  begin mul_a = czsy; mul_b = ccx; end
      5'd6:  begin mul_a = sz;   mul_b = sx;  end
      5'd7:  begin mul_a = sz;   mul_b = ccy; end
      5'd8:  begin mul_a = szsy; mul_b = sx;  end
      5'd9:  begin mul_a = ccz;  mul_b = ccx; end
      5'd10: begin mul_a = szsy; mul_b = ccx; end
      5'd11: begin mul_a = ccz;  mul_b = sx;  end
      5'd12: begin mul_a = sy;   mul_b = -(TrigW'(1) <<< 30); end
      5'd13: begin mul_a = ccy;  mul_b = sx;  end
      5'd14: begin mul_a = ccy;  mul_b = ccx; end
      default: ;
    endcase
  end
  assign prod = 67'(mul_a) * 67'(mul_b);

  function automatic coeff_t to_coeff(input logic signed [67:0] q);
    logic signed [67:0] v;
    v = (q + (68'sd1 <<< (59 - CoeffFrac))) >>> (60 - CoeffFrac);
    if (v > (68'sd1 <<< CoeffFrac)) v = 68'sd1 <<< CoeffFrac;
    if (v < -(68'sd1 <<< CoeffFrac)) v = -(68'sd1 <<< CoeffFrac);
    return v[CoeffW-1:0];
  endfunction

  // Sequencer: restart on any angle write
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      axis    <= '0;
      step    <= '0;
      op      <= '0;
      for (int i = 0; i < 9; i++) coeffs[i] <= (i % 4 == 0) ? coeff_t'(1 <<< CoeffFrac) : '0;
    end else if (rebuild) begin
      state <= S_REDUCE;
      axis  <= '0;
    end else begin
      unique case (state) inside
        S_IDLE, S_DONE: state <= state;
        S_REDUCE: begin
          if (ang_wrap > Deg90) begin
            ang <= ang_wrap - Deg180; flip <= 1'b1;
          end else if (ang_wrap < -Deg90) begin
            ang <= ang_wrap + Deg180; flip <= 1'b1;
          end else begin
            ang <= ang_wrap; flip <= 1'b0;
          end
          cx    <= CordicGain;
          cy    <= '0;
          step  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (ang >= 0) begin
            cx <= cx - dx; cy <= cy + dy; ang <= ang - atan_deg(step);
          end else begin
            cx <= cx + dx; cy <= cy - dy; ang <= ang + atan_deg(step);
          end
          if (step == StepW'(CordicSteps - 1)) state <= S_STORE;
          step <= step + 1'b1;
        end
        S_STORE: begin
          trig[{axis, 1'b0}] <= flip ? -cy : cy;
          trig[{axis, 1'b1}] <= flip ? -cx : cx;
          if (axis == 2'd2) begin
            op    <= '0;
            state <= S_MUL;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_REDUCE;
          end
        end
        S_MUL: begin
          case (op) inside
            5'd0: czsy <= TrigW'((prod + (67'sd1 <<< 29)) >>> 30);
            5'd1: szsy <= TrigW'((prod + (67'sd1 <<< 29)) >>> 30);
            5'd2: coeffs[0] <= to_coeff(68'(prod));
            5'd3, 5'd5, 5'd8, 5'd10: acc <= 68'(prod);
            5'd4:  coeffs[1] <= to_coeff(acc - 68'(prod));
            5'd6:  coeffs[2] <= to_coeff(acc + 68'(prod));
            5'd7:  coeffs[3] <= to_coeff(68'(prod));
            5'd9:  coeffs[4] <= to_coeff(acc + 68'(prod));
            5'd11: coeffs[5] <= to_coeff(acc - 68'(prod));
            5'd12: coeffs[6] <= to_coeff(68'(prod));
            5'd13: coeffs[7] <= to_coeff(68'(prod));
            5'd14: coeffs[8] <= to_coeff(68'(prod));
            default: ;
          endcase
          if (op == 5'd14) state <= S_DONE;
          op <= op + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/euler_rotate_translate_points.sv =====
// ----------------------------------------------------------------------------
// euler_rotate_translate_points
// Rigid-body transform of points: global = R * local + offset, saturated.
// ----------------------------------------------------------------------------
// Each point passes the input, product and output registers before done; one
// point is accepted every cycle while busy is low. An angle write rebuilds the
// matrix with the shared CORDIC and multiplier; busy is high meanwhile.
// Reset: matrix is identity, offsets and angles are zero, no item in flight.
// done cannot be held off by the receiver.
module euler_rotate_translate_points import ertp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  point_in_t             point_in,
  output logic                  done,
  output point_out_t            point_out,
  input  logic                  cfg_we,
  input  logic [CfgIdxW-1:0]    cfg_index,
  input  logic [CfgDataW-1:0]   cfg_data
);

  logic signed [AngleW-1:0] angle_x, angle_y, angle_z;
  logic signed [CoordW-1:0] offset [3];
  matrix_t coeffs;
  logic rebuild;
  logic [6:0] hold_cnt;

  assign rebuild = cfg_we && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y ||
                              cfg_index == REG_ANGLE_Z);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_x <= '0; angle_y <= '0; angle_z <= '0;
      offset[0] <= '0; offset[1] <= '0; offset[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_X:  angle_x <= cfg_data[AngleW-1:0];
        REG_ANGLE_Y:  angle_y <= cfg_data[AngleW-1:0];
        REG_ANGLE_Z:  angle_z <= cfg_data[AngleW-1:0];
        REG_OFFSET_X: offset[0] <= cfg_data;
        REG_OFFSET_Y: offset[1] <= cfg_data;
        REG_OFFSET_Z: offset[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off items while the matrix is rebuilt
  always_ff @(posedge clk) begin
    if (rst) hold_cnt <= '0;
    else if (rebuild) hold_cnt <= 7'd85;
    else if (hold_cnt != '0) hold_cnt <= hold_cnt - 1'b1;
  end
  assign busy = (hold_cnt != '0);

  ertp_matrix u_matrix (
    .clk, .rst, .rebuild, .angle_x, .angle_y, .angle_z, .coeffs
  );

  // Stage 1: input register
  logic v1, v2;
  logic signed [CoordW-1:0] p [3];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start && !busy;
    p[0] <= point_in.local_x;
    p[1] <= point_in.local_y;
    p[2] <= point_in.local_z;
  end

  // Stage 2: nine products
  logic signed [CoordW+CoeffW-1:0] prod [9];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    for (int i = 0; i < 9; i++) prod[i] <= coeffs[i] * p[i % 3];
  end

  // Stage 3: sum, round, offset, saturate
  logic signed [CoordW+CoeffW+2:0] acc [3];
  logic signed [CoordW+CoeffW+2:0] g [3];
  logic signed [CoordW-1:0] res [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 53'(prod[3*r]) + 53'(prod[3*r+1]) + 53'(prod[3*r+2])
               + (53'sd1 <<< (CoeffFrac - 1));
      g[r] = (acc[r] >>> CoeffFrac) + 53'(offset[r]);
      if (g[r] > 53'sd2147483647) res[r] = 32'sh7fffffff;
      else if (g[r] < -53'sd2147483648) res[r] = 32'sh80000000;
      else res[r] = g[r][CoordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v2;
    point_out.global_x <= res[0];
    point_out.global_y <= res[1];
    point_out.global_z <= res[2];
  end

endmodule

// ===== hdl/ertp_checker.sv =====
// ----------------------------------------------------------------------------
// ertp_checker
// Port-level checks on the point transform block.
// ----------------------------------------------------------------------------
module ertp_checker import ertp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic cfg_we,
  input logic [CfgIdxW-1:0] cfg_index
);

  logic angle_wr;
  assign angle_wr = cfg_we && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y ||
                               cfg_index == REG_ANGLE_Z);

  // An accepted item gives a result through the input, product and output registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done) else $error("result missing");

  // No result without an accepted item ahead of it in the pipeline
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3)) else $error("spurious result");

  // Angle write holds off items
  a_busy_after_angle: assert property (@(posedge clk) disable iff (rst)
    angle_wr |=> busy) else $error("busy missing after angle write");

  // Reset leaves nothing in flight
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done && !busy) else $error("activity after reset");

endmodule

bind euler_rotate_translate_points ertp_checker u_ertp_checker (
  .clk, .rst, .start, .busy, .done, .cfg_we, .cfg_index
);

// ===== dv/euler_rotate_translate_points_test.sv =====
// ----------------------------------------------------------------------------
// euler_rotate_translate_points_test
// Self-checking bench for the point transform: a directed table followed by
// randomised phases of register settings and point streams. Every point out
// is compared against a typed result or a bit-true CORDIC, matrix and saturation predictor.
// ----------------------------------------------------------------------------
module euler_rotate_translate_points_test;
  import ertp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_7 = 3'd7;
  localparam longint ANG_MAX = 23592960;
  localparam longint TURN_HALF = 11796480;
  localparam longint TURN_QTR = 5898240;
  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  point_in_t point_in = '0;
  logic done;
  point_out_t point_out;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  euler_rotate_translate_points DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point_in(point_in),
    .done(done), .point_out(point_out), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state
  longint angle_q16 [3];
  longint offset_q16 [3];
  longint coeff [9];
  const longint atan_q16 [20] = '{2949120, 1740967, 919879, 466945, 234379,
    117304, 58665, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7};

  point_out_t pending_points [$];
  int mismatches = 0;
  int points_sent = 0;
  int points_checked = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic void cordic_sin_cos(longint ang, output longint s,
                                         output longint c);
    longint a, x, y, dx, dy;
    bit flip;
    a = ang % (2 * TURN_HALF);
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (a < 0) a += 2 * TURN_HALF;
    if (a > TURN_HALF) a -= 2 * TURN_HALF;
    if (a > TURN_QTR) begin
      a -= TURN_HALF;
      flip = 1'b1;
    end else if (a < -TURN_QTR) begin
      a += TURN_HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= atan_q16[i];
      end else begin
        x += dx; y -= dy; a += atan_q16[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint coeff_of(longint q60);
    longint lim, v;
    lim = longint'(1) << CoeffFrac;
    v = round_half_up(q60, 60 - CoeffFrac);
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic void rebuild_rotation();
    longint sx, cx, sy, cy, sz, cz, czsy, szsy;
    cordic_sin_cos(angle_q16[0], sx, cx);
    cordic_sin_cos(angle_q16[1], sy, cy);
    cordic_sin_cos(angle_q16[2], sz, cz);
    czsy = round_half_up(cz * sy, 30);
    szsy = round_half_up(sz * sy, 30);
    coeff[0] = coeff_of(cz * cy);
    coeff[1] = coeff_of(czsy * sx - sz * cx);
    coeff[2] = coeff_of(czsy * cx + sz * sx);
    coeff[3] = coeff_of(sz * cy);
    coeff[4] = coeff_of(szsy * sx + cz * cx);
    coeff[5] = coeff_of(szsy * cx - cz * sx);
    coeff[6] = coeff_of(-(sy * (longint'(1) << 30)));
    coeff[7] = coeff_of(cy * sx);
    coeff[8] = coeff_of(cy * cx);
  endfunction

  function automatic point_out_t transform_point(point_in_t p);
    longint v [3];
    longint acc, g;
    logic signed [CoordW-1:0] r [3];
    v[0] = p.local_x; v[1] = p.local_y; v[2] = p.local_z;
    for (int row = 0; row < 3; row++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += coeff[row * 3 + k] * v[k];
      g = round_half_up(acc, CoeffFrac) + offset_q16[row];
      if (g > 64'sd2147483647) g = 64'sd2147483647;
      if (g < -64'sd2147483648) g = -64'sd2147483648;
      r[row] = g[CoordW-1:0];
    end
    return '{global_z: r[2], global_y: r[1], global_x: r[0]};
  endfunction

  // Wait until every point is back and the block is free, then write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    if (idx < 3) begin
      angle_q16[idx] = longint'($signed(data[AngleW-1:0]));
      rebuild_rotation();
    end else if (idx < 6) begin
      offset_q16[idx - 3] = longint'($signed(data));
    end
  endtask

  // Hold off for the given gap, then present the point until it is taken
  task automatic send_point(point_in_t p, bit typed, point_out_t typed_exp,
                            int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    point_in <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_points.push_back(typed ? typed_exp : transform_point(p));
    points_sent++;
  endtask

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return CoordW'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return CoordW'($signed($urandom_range(0, 2 * 65536 * 4096))
                              - 65536 * 4096);
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] rand_angle();
    longint a;
    case ($urandom_range(0, 4))
      0: a = ANG_MAX;
      1: a = -ANG_MAX;
      2: a = longint'($urandom_range(0, 8)) * TURN_QTR / 2 - 2 * TURN_HALF;
      default: a = longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
    endcase
    return a[CfgDataW-1:0];
  endfunction

  // Directed stimulus: register writes and points, some with typed results
  typedef struct {
    bit is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] data;
    point_in_t p;
    bit typed;
    point_out_t exp_pt;
  } step_t;

  localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] PMIN = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] NONE = 32'hFFFF_0000;

  step_t directed [] = '{
    // Identity after reset: points pass through unchanged
    '{0, 0, 0, '{ONE, NONE, ONE}, 1, '{ONE, NONE, ONE}},
    '{0, 0, 0, '{PMAX, PMAX, PMAX}, 1, '{PMAX, PMAX, PMAX}},
    '{0, 0, 0, '{PMIN, PMIN, PMIN}, 1, '{PMIN, PMIN, PMIN}},
    '{0, 0, 0, '{32'hFFFF_FFFF, 32'h0, 32'h1}, 1, '{32'hFFFF_FFFF, 32'h0, 32'h1}},
    // Offsets at the limits and at one, with the matrix still the identity: saturation
    '{1, REG_OFFSET_X, PMAX, '0, 0, '0},
    '{1, REG_OFFSET_Y, PMIN, '0, 0, '0},
    '{1, REG_OFFSET_Z, ONE, '0, 0, '0},
    '{0, 0, 0, '{PMAX, NONE, ONE}, 1, '{PMAX, PMIN, PMAX}},
    '{0, 0, 0, '{PMIN, PMIN, PMIN}, 1, '{32'h8001_0000, PMIN, 32'hFFFF_FFFF}},
    // Unused register indexes are ignored
    '{1, REG_SPARE_6, PMAX, '0, 0, '0},
    '{1, REG_SPARE_7, PMIN, '0, 0, '0},
    '{0, 0, 0, '{ONE, ONE, ONE}, 1, '{32'h0002_0000, 32'h8001_0000, PMAX}},
    // Zero angle rebuilt by CORDIC: coefficients may saturate at one
    '{1, REG_OFFSET_X, 32'h0, '0, 0, '0},
    '{1, REG_OFFSET_Y, 32'h0, '0, 0, '0},
    '{1, REG_ANGLE_X, 32'h0, '0, 0, '0},
    '{0, 0, 0, '{PMAX, PMIN, ONE}, 0, '0},
    // Full turns, a quarter turn, three quarters of a turn and a half turn
    '{1, REG_ANGLE_X, 32'(ANG_MAX), '0, 0, '0},
    '{1, REG_ANGLE_Y, 32'(-ANG_MAX), '0, 0, '0},
    '{1, REG_ANGLE_Z, 32'(TURN_QTR), '0, 0, '0},
    '{0, 0, 0, '{ONE, NONE, PMAX}, 0, '0},
    '{1, REG_ANGLE_Y, 32'(TURN_HALF + TURN_QTR), '0, 0, '0},
    '{1, REG_ANGLE_X, 32'(-TURN_HALF), '0, 0, '0},
    '{0, 0, 0, '{PMIN, ONE, PMAX}, 0, '0},
    '{0, 0, 0, '{32'h0012_3456, 32'hFFED_CBA9, 32'h0000_8000}, 0, '0}
  };

  // Compare every point out against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected point out %h", point_out);
      end else begin
        point_out_t want;
        want = pending_points.pop_front();
        points_checked++;
        if (point_out.global_x !== want.global_x ||
            point_out.global_y !== want.global_y ||
            point_out.global_z !== want.global_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: point %0d exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                     points_checked, want.global_x, want.global_y,
                     want.global_z, point_out.global_x, point_out.global_y,
                     point_out.global_z);
        end
      end
    end
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 3; i++) begin
      angle_q16[i] = 0;
      offset_q16[i] = 0;
    end
    for (int i = 0; i < 9; i++) coeff[i] = (i % 4 == 0) ? 65536 : 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].data);
      else send_point(directed[i].p, directed[i].typed, directed[i].exp_pt,
                      $urandom_range(0, 2));
    end

    // Random phases: new settings, then a burst of points
    for (int ph = 0; ph < 12; ph++) begin
      for (int r = 0; r < 6; r++) begin
        if (r < 3) write_reg(CfgIdxW'(r), rand_angle());
        else if ($urandom_range(0, 3) == 0)
          write_reg(CfgIdxW'(r), $urandom_range(0, 1) ? PMAX : PMIN);
        else write_reg(CfgIdxW'(r), $urandom());
      end
      for (int n = 0; n < 150; n++)
        send_point('{rand_coord(), rand_coord(), rand_coord()}, 0, '0,
                   (ph % 3 == 0) ? 0 : $urandom_range(0, 8));
    end

    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d points, checked %0d, over %0d register writes; %0d mismatches",
             points_sent, points_checked, reg_writes, mismatches);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
